@@ sv/kcs_pkg.sv @@
package kcs_pkg;

  localparam int MAX_KEYS_DEF = 256;
  localparam int FRAC_BITS = 16;
  localparam int CQ = 24;

  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CORDIC_STEPS = 24;

  localparam logic [FRAC_BITS:0] FIX_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam longint NEAR_COS_L = (64'sd9995 <<< FRAC_BITS) / 10000;
  localparam logic signed [63:0] NEAR_COS = 64'(NEAR_COS_L);
  localparam longint LEN_EPS_L = (64'sd1 <<< FRAC_BITS) / 1000000;
  localparam logic [63:0] LEN_EPS = 64'(LEN_EPS_L);
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd10188014;
  localparam logic [63:0] ACOS_ONE_SQ = 64'd1 << (2 * CQ);
  localparam logic signed [64:0] WEIGHT_LIM = 65'sd2 <<< CQ;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_LINEAR = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [69:0] hi_lim;
    logic signed [69:0] lo_lim;
    hi_lim = 70'sh7FFFFFFF;
    lo_lim = -70'sh80000000;
    if (v > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [26:0] clamp_weight(input logic signed [64:0] w);
    if (w > WEIGHT_LIM) begin
      return 27'(WEIGHT_LIM);
    end else if (w < -WEIGHT_LIM) begin
      return 27'(-WEIGHT_LIM);
    end
    return w[26:0];
  endfunction

  function automatic logic signed [31:0] atan_q24(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd13176795;
      5'd1: v = 32'sd7778716;
      5'd2: v = 32'sd4110060;
      5'd3: v = 32'sd2086331;
      5'd4: v = 32'sd1047214;
      5'd5: v = 32'sd524117;
      5'd6: v = 32'sd262123;
      5'd7: v = 32'sd131069;
      5'd8: v = 32'sd65536;
      5'd9: v = 32'sd32768;
      5'd10: v = 32'sd16384;
      5'd11: v = 32'sd8192;
      5'd12: v = 32'sd4096;
      5'd13: v = 32'sd2048;
      5'd14: v = 32'sd1024;
      5'd15: v = 32'sd512;
      5'd16: v = 32'sd256;
      5'd17: v = 32'sd128;
      5'd18: v = 32'sd64;
      5'd19: v = 32'sd32;
      5'd20: v = 32'sd16;
      5'd21: v = 32'sd8;
      5'd22: v = 32'sd4;
      5'd23: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/kcs_ram.sv @@
module kcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/keyframe_channel_sampler_unit.sv @@
// Channel   Direction  Beat contents
// s_axis    in         tuser: mode; tdata: key_index, key_time, value_x..w, sample_time
// m_axis    out        tuser: no_keys; tdata: out_x, out_y, out_z, out_w
// apb       in/out     rotation_path, linear_interp, key_count at 0x0, 0x4, 0x8
// A load beat is written to the key tables as it is accepted and leaves the sequencer idle.
// A sample beat runs in step mode, as a vector lerp, as a slerp or as a normalized lerp;
// the 64-step divider, 32-step square root and 24-step CORDIC each run one step per
// cycle.
// Reset is synchronous and leaves the key tables as they are.
// A finished result waits in the output register; while it is not taken the sequencer
// holds in its final state and s_tready stays low.
module keyframe_channel_sampler_unit #(
  parameter int MAX_KEYS = kcs_pkg::MAX_KEYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] key_index, [39:8] key_time, [71:40] value_x, [103:72] value_y,
  // [135:104] value_z, [167:136] value_w, [199:168] sample_time
  input  logic [199:0] s_tdata,
  // [0] mode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  output logic [127:0] m_tdata,
  // [0] no_keys
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int XW = (AW > 8) ? AW : 8;
  localparam int F = kcs_pkg::FRAC_BITS;

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_T0    = 6'd1;
  localparam logic [5:0] ST_TN    = 6'd2;
  localparam logic [5:0] ST_SRCH  = 6'd3;
  localparam logic [5:0] ST_SCMP  = 6'd4;
  localparam logic [5:0] ST_RK    = 6'd5;
  localparam logic [5:0] ST_RK2   = 6'd6;
  localparam logic [5:0] ST_FIN   = 6'd7;
  localparam logic [5:0] ST_TF    = 6'd8;
  localparam logic [5:0] ST_TDONE = 6'd9;
  localparam logic [5:0] ST_RA    = 6'd10;
  localparam logic [5:0] ST_RB    = 6'd11;
  localparam logic [5:0] ST_RB2   = 6'd12;
  localparam logic [5:0] ST_LMUL  = 6'd13;
  localparam logic [5:0] ST_LADD  = 6'd14;
  localparam logic [5:0] ST_DOT   = 6'd15;
  localparam logic [5:0] ST_DACC  = 6'd16;
  localparam logic [5:0] ST_DSGN  = 6'd17;
  localparam logic [5:0] ST_DSEL  = 6'd18;
  localparam logic [5:0] ST_ACQ   = 6'd19;
  localparam logic [5:0] ST_ACOS0 = 6'd20;
  localparam logic [5:0] ST_AC1   = 6'd21;
  localparam logic [5:0] ST_SN1   = 6'd22;
  localparam logic [5:0] ST_SN2   = 6'd23;
  localparam logic [5:0] ST_SN3   = 6'd24;
  localparam logic [5:0] ST_SN4   = 6'd25;
  localparam logic [5:0] ST_SN5   = 6'd26;
  localparam logic [5:0] ST_W1    = 6'd27;
  localparam logic [5:0] ST_W2    = 6'd28;
  localparam logic [5:0] ST_WM1   = 6'd29;
  localparam logic [5:0] ST_WM2   = 6'd30;
  localparam logic [5:0] ST_WM3   = 6'd31;
  localparam logic [5:0] ST_SQ    = 6'd32;
  localparam logic [5:0] ST_SQA   = 6'd33;
  localparam logic [5:0] ST_SQS   = 6'd34;
  localparam logic [5:0] ST_LEN   = 6'd35;
  localparam logic [5:0] ST_NDIVS = 6'd36;
  localparam logic [5:0] ST_NDONE = 6'd37;
  localparam logic [5:0] ST_DIV   = 6'd38;
  localparam logic [5:0] ST_SQRT  = 6'd39;
  localparam logic [5:0] ST_CORD  = 6'd40;

  // Configuration registers.
  logic       rotation_path;
  logic       linear_interp;
  logic [8:0] key_count;

  // Input fields.
  logic [7:0]         key_index;
  logic signed [31:0] key_time;
  logic signed [31:0] sample_time;
  assign key_index = s_tdata[7:0];
  assign key_time = s_tdata[39:8];
  assign sample_time = s_tdata[199:168];

  // Sequencer and datapath registers.
  logic [5:0]         state;
  logic [5:0]         ret;
  logic [5:0]         cnt;
  logic [1:0]         k;
  logic               nk;
  logic signed [31:0] time_s;
  logic [NW-1:0]      n_r;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [AW-1:0]      kaddr;
  logic signed [31:0] tlo;
  logic signed [31:0] thi;
  logic [F:0]         t_f;
  logic signed [31:0] a [4];
  logic signed [32:0] b [4];
  logic signed [31:0] r [4];
  logic signed [63:0] dot;
  logic [63:0]        acc;
  logic signed [31:0] theta;
  logic signed [31:0] sth;
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic signed [26:0] wa;
  logic signed [26:0] wb;
  logic signed [67:0] accs;
  logic signed [67:0] prod;

  // Iterative units.
  logic [63:0]        div_q;
  logic [32:0]        div_rem;
  logic [32:0]        div_den;
  logic               div_neg;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic               cvec;

  // Key tables.
  logic               wr_key;
  logic [XW-1:0]      idx_w;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_time_raw;
  logic [63:0]        rd_xy;
  logic [63:0]        rd_zw;
  logic signed [31:0] rd_time;
  logic signed [31:0] rk [4];

  // Combinational helpers.
  logic [NW-1:0]      n_in;
  logic [NW-1:0]      nm1;
  logic [AW-1:0]      last;
  logic [AW:0]        lh_sum;
  logic [AW-1:0]      mid;
  logic               gap;
  logic signed [32:0] rng;
  logic signed [32:0] num;
  logic signed [31:0] acos_x;
  logic [F:0]         t_inv;
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [64:0] div_res;
  logic [33:0]        dtry;
  logic               dge;
  logic [63:0]        sq_sum;
  logic [64:0]        acc_sum;
  logic signed [31:0] csx;
  logic signed [31:0] csy;
  logic signed [31:0] cat;

  assign idx_w = XW'(key_index);
  assign wr_key = s_tvalid && s_tready && (s_tuser == kcs_pkg::MODE_LOAD) &&
                  (32'(key_index) < 32'(MAX_KEYS));

  kcs_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk(clk), .we(wr_key), .waddr(idx_w[AW-1:0]), .wdata(key_time),
    .raddr(rd_addr), .rdata(rd_time_raw)
  );

  kcs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_xy_ram (
    .clk(clk), .we(wr_key), .waddr(idx_w[AW-1:0]), .wdata(s_tdata[103:40]),
    .raddr(rd_addr), .rdata(rd_xy)
  );

  kcs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_zw_ram (
    .clk(clk), .we(wr_key), .waddr(idx_w[AW-1:0]), .wdata(s_tdata[167:104]),
    .raddr(rd_addr), .rdata(rd_zw)
  );

  assign rd_time = rd_time_raw;
  assign rk[0] = rd_xy[31:0];
  assign rk[1] = rd_xy[63:32];
  assign rk[2] = rd_zw[31:0];
  assign rk[3] = rd_zw[63:32];

  assign n_in = (32'(key_count) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign nm1 = n_r - NW'(1);
  assign last = nm1[AW-1:0];
  assign lh_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = lh_sum[AW:1];
  assign gap = ({1'b0, lo} + (AW + 1)'(1)) < {1'b0, hi};
  assign rng = 33'(thi) - 33'(tlo);
  assign num = 33'(time_s) - 33'(tlo);
  assign acos_x = 32'(dot <<< (kcs_pkg::CQ - F));
  assign t_inv = kcs_pkg::FIX_ONE - t_f;
  assign div_res = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign dtry = {div_rem, div_q[63]};
  assign dge = dtry >= {1'b0, div_den};
  assign sq_sum = sq_res + sq_bit;
  assign acc_sum = {1'b0, acc} + {1'b0, prod[63:0]};
  assign csx = cx >>> cnt[4:0];
  assign csy = cy >>> cnt[4:0];
  assign cat = kcs_pkg::atan_q24(cnt[4:0]);

  always_comb begin
    case (state)
      ST_T0:   rd_addr = last;
      ST_SRCH: rd_addr = mid;
      ST_RK:   rd_addr = kaddr;
      ST_RA:   rd_addr = lo;
      ST_RB:   rd_addr = hi;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_LMUL: begin
        ma = 34'(t_f);
        mb = 34'(b[k]) - 34'(a[k]);
      end
      ST_DOT: begin
        ma = 34'(a[k]);
        mb = 34'(b[k]);
      end
      ST_DSEL: begin
        ma = 34'(acos_x);
        mb = 34'(acos_x);
      end
      ST_SQ: begin
        ma = 34'(r[k]);
        mb = 34'(r[k]);
      end
      ST_SN1: begin
        ma = 34'(t_inv);
        mb = 34'(theta);
      end
      ST_SN3: begin
        ma = 34'(t_f);
        mb = 34'(theta);
      end
      ST_WM1: begin
        ma = 34'(wa);
        mb = 34'(a[k]);
      end
      ST_WM2: begin
        ma = 34'(wb);
        mb = 34'(b[k]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      prod <= ma * mb;
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tuser == kcs_pkg::MODE_SAMPLE) begin
            time_s <= sample_time;
            n_r <= n_in;
            nk <= (n_in == '0);
            if (n_in == '0) begin
              for (int i = 0; i < 4; i++) begin
                r[i] <= '0;
              end
              state <= ST_FIN;
            end else begin
              state <= ST_T0;
            end
          end
        end
        ST_T0: begin
          tlo <= rd_time;
          if (n_r == NW'(1) || time_s <= rd_time) begin
            kaddr <= '0;
            state <= ST_RK;
          end else begin
            state <= ST_TN;
          end
        end
        ST_TN: begin
          thi <= rd_time;
          if (time_s >= rd_time) begin
            kaddr <= last;
            state <= ST_RK;
          end else begin
            lo <= '0;
            hi <= last;
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (gap) begin
            state <= ST_SCMP;
          end else if (!linear_interp) begin
            kaddr <= lo;
            state <= ST_RK;
          end else begin
            state <= ST_TF;
          end
        end
        ST_SCMP: begin
          if (rd_time <= time_s) begin
            lo <= mid;
            tlo <= rd_time;
          end else begin
            hi <= mid;
            thi <= rd_time;
          end
          state <= ST_SRCH;
        end
        ST_RK: state <= ST_RK2;
        ST_RK2: begin
          for (int i = 0; i < 4; i++) begin
            r[i] <= rk[i];
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {rotation_path ? r[3] : 32'sd0, r[2], r[1], r[0]};
            m_tuser <= nk;
            m_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_TF: begin
          if (rng > 33'sd0 && num > 33'sd0) begin
            div_q <= 64'(num[31:0]) << F;
            div_rem <= '0;
            div_den <= rng;
            div_neg <= 1'b0;
            cnt <= '0;
            ret <= ST_TDONE;
            state <= ST_DIV;
          end else begin
            t_f <= '0;
            state <= ST_RA;
          end
        end
        ST_TDONE: begin
          t_f <= (div_q > 64'(kcs_pkg::FIX_ONE)) ? kcs_pkg::FIX_ONE : div_q[F:0];
          state <= ST_RA;
        end
        ST_RA: state <= ST_RB;
        ST_RB: begin
          for (int i = 0; i < 4; i++) begin
            a[i] <= rk[i];
          end
          state <= ST_RB2;
        end
        ST_RB2: begin
          for (int i = 0; i < 4; i++) begin
            b[i] <= 33'(rk[i]);
          end
          dot <= '0;
          k <= '0;
          state <= rotation_path ? ST_DOT : ST_LMUL;
        end
        ST_LMUL: state <= ST_LADD;
        ST_LADD: begin
          r[k] <= kcs_pkg::sat32(70'(a[k]) + 70'(prod >>> F));
          if (k == 2'd3 || (k == 2'd2 && !rotation_path)) begin
            k <= '0;
            acc <= '0;
            state <= rotation_path ? ST_SQ : ST_FIN;
          end else begin
            k <= k + 2'd1;
            state <= ST_LMUL;
          end
        end
        ST_DOT: state <= ST_DACC;
        ST_DACC: begin
          dot <= dot + 64'(prod >>> F);
          k <= k + 2'd1;
          state <= (k == 2'd3) ? ST_DSGN : ST_DOT;
        end
        ST_DSGN: begin
          if (dot < 64'sd0) begin
            for (int i = 0; i < 4; i++) begin
              b[i] <= -b[i];
            end
            dot <= -dot;
          end
          k <= '0;
          state <= ST_DSEL;
        end
        ST_DSEL: state <= (dot > kcs_pkg::NEAR_COS) ? ST_LMUL : ST_ACQ;
        ST_ACQ: begin
          sq_n <= kcs_pkg::ACOS_ONE_SQ - prod[63:0];
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          cnt <= '0;
          ret <= ST_ACOS0;
          state <= ST_SQRT;
        end
        ST_ACOS0: begin
          cx <= acos_x;
          cy <= sq_res[31:0];
          cz <= '0;
          cvec <= 1'b1;
          cnt <= '0;
          ret <= ST_AC1;
          state <= ST_CORD;
        end
        ST_AC1: begin
          theta <= cz;
          cx <= kcs_pkg::CORDIC_GAIN;
          cy <= '0;
          cvec <= 1'b0;
          cnt <= '0;
          ret <= ST_SN1;
          state <= ST_CORD;
        end
        ST_SN1: begin
          sth <= (cy < 32'sd1) ? 32'sd1 : cy;
          state <= ST_SN2;
        end
        ST_SN2: begin
          cx <= kcs_pkg::CORDIC_GAIN;
          cy <= '0;
          cz <= 32'(prod >>> F);
          cnt <= '0;
          ret <= ST_SN3;
          state <= ST_CORD;
        end
        ST_SN3: begin
          sa <= cy;
          state <= ST_SN4;
        end
        ST_SN4: begin
          cx <= kcs_pkg::CORDIC_GAIN;
          cy <= '0;
          cz <= 32'(prod >>> F);
          cnt <= '0;
          ret <= ST_SN5;
          state <= ST_CORD;
        end
        ST_SN5: begin
          sb <= cy;
          div_q <= 64'(kcs_pkg::abs32(sa)) << kcs_pkg::CQ;
          div_rem <= '0;
          div_den <= 33'(sth);
          div_neg <= sa[31];
          cnt <= '0;
          ret <= ST_W1;
          state <= ST_DIV;
        end
        ST_W1: begin
          wa <= kcs_pkg::clamp_weight(div_res);
          div_q <= 64'(kcs_pkg::abs32(sb)) << kcs_pkg::CQ;
          div_rem <= '0;
          div_neg <= sb[31];
          cnt <= '0;
          ret <= ST_W2;
          state <= ST_DIV;
        end
        ST_W2: begin
          wb <= kcs_pkg::clamp_weight(div_res);
          k <= '0;
          state <= ST_WM1;
        end
        ST_WM1: state <= ST_WM2;
        ST_WM2: begin
          accs <= prod;
          state <= ST_WM3;
        end
        ST_WM3: begin
          r[k] <= kcs_pkg::sat32(70'((accs + prod) >>> kcs_pkg::CQ));
          k <= k + 2'd1;
          state <= (k == 2'd3) ? ST_FIN : ST_WM1;
        end
        ST_SQ: state <= ST_SQA;
        ST_SQA: begin
          acc <= acc_sum[64] ? '1 : acc_sum[63:0];
          k <= k + 2'd1;
          state <= (k == 2'd3) ? ST_SQS : ST_SQ;
        end
        ST_SQS: begin
          sq_n <= acc;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          cnt <= '0;
          ret <= ST_LEN;
          state <= ST_SQRT;
        end
        ST_LEN: begin
          k <= '0;
          state <= (sq_res > kcs_pkg::LEN_EPS) ? ST_NDIVS : ST_FIN;
        end
        ST_NDIVS: begin
          div_q <= 64'(kcs_pkg::abs32(r[k])) << F;
          div_rem <= '0;
          div_den <= sq_res[32:0];
          div_neg <= r[k][31];
          cnt <= '0;
          ret <= ST_NDONE;
          state <= ST_DIV;
        end
        ST_NDONE: begin
          r[k] <= kcs_pkg::sat32(70'(div_res));
          k <= k + 2'd1;
          state <= (k == 2'd3) ? ST_FIN : ST_NDIVS;
        end
        ST_DIV: begin
          div_rem <= dge ? 33'(dtry - {1'b0, div_den}) : dtry[32:0];
          div_q <= {div_q[62:0], dge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(kcs_pkg::DIV_STEPS - 1)) begin
            state <= ret;
          end
        end
        ST_SQRT: begin
          if (sq_n >= sq_sum) begin
            sq_n <= sq_n - sq_sum;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(kcs_pkg::SQRT_STEPS - 1)) begin
            state <= ret;
          end
        end
        ST_CORD: begin
          if (cvec ? (cy > 32'sd0) : (cz < 32'sd0)) begin
            cx <= cx + csy;
            cy <= cy - csx;
            cz <= cvec ? cz + cat : cz + cat;
          end else begin
            cx <= cx - csy;
            cy <= cy + csx;
            cz <= cz - cat;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(kcs_pkg::CORDIC_STEPS - 1)) begin
            state <= ret;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_path <= 1'b0;
      linear_interp <= 1'b0;
      key_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        kcs_pkg::REG_ROTATION: rotation_path <= pwdata[0];
        kcs_pkg::REG_LINEAR:   linear_interp <= pwdata[0];
        kcs_pkg::REG_COUNT:    key_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      kcs_pkg::REG_ROTATION: prdata = {31'd0, rotation_path};
      kcs_pkg::REG_LINEAR:   prdata = {31'd0, linear_interp};
      kcs_pkg::REG_COUNT:    prdata = {23'd0, key_count};
      default:               prdata = '0;
    endcase
  end

endmodule

@@ dv/keyframe_channel_sampler_unit_test.sv @@
`timescale 1ns / 1ps

module keyframe_channel_sampler_unit_test;

  typedef longint quad_t[4];

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        no_keys;
  } sample_out_t;

  localparam int KEYS = 256;
  localparam longint ONE_Q = 64'sd1 << kcs_pkg::FRAC_BITS;
  localparam longint NEAR_PARALLEL = (64'sd9995 << kcs_pkg::FRAC_BITS) / 10000;
  localparam longint MIN_LEN = ONE_Q / 1000000;
  localparam int SETTLE_CYCLES = 600;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [199:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  keyframe_channel_sampler_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [31:0] key_tm[KEYS];
  logic signed [31:0] key_val[KEYS][4];
  int written_n;
  logic cfg_rotation;
  logic cfg_linear;
  logic [8:0] cfg_count;

  sample_out_t expected_samples[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;

  const longint arctan_tab[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint arc_cosine(longint x);
    longint y;
    longint z;
    longint nx;
    y = longint'(int_sqrt(longint'((64'sd1 << (2 * kcs_pkg::CQ)) - x * x)));
    z = 0;
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint sine(longint z);
    longint x;
    longint y;
    longint nx;
    x = 10188014;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_tab[i];
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic longint clamp_w(longint w);
    longint lim;
    lim = 64'sd2 << kcs_pkg::CQ;
    if (w > lim) return lim;
    if (w < -lim) return -lim;
    return w;
  endfunction

  function automatic quad_t key_at(int k);
    quad_t v;
    for (int i = 0; i < 4; i++) v[i] = key_val[k][i];
    return v;
  endfunction

  function automatic quad_t rotation_blend(quad_t a, quad_t b, longint t);
    longint dot;
    longint theta;
    longint s_full;
    longint s_a;
    longint s_b;
    longint wa;
    longint wb;
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned len;
    quad_t b2;
    quad_t r;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += (a[i] * b[i]) >>> kcs_pkg::FRAC_BITS;
    for (int i = 0; i < 4; i++) b2[i] = (dot < 0) ? -b[i] : b[i];
    if (dot < 0) dot = -dot;
    if (dot > NEAR_PARALLEL) begin
      acc = 0;
      for (int i = 0; i < 4; i++) begin
        r[i] = sat_word(a[i] + ((t * (b2[i] - a[i])) >>> kcs_pkg::FRAC_BITS));
        sq = longint'(r[i] * r[i]);
        acc = (acc + sq < acc) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
      end
      len = int_sqrt(acc);
      if (longint'(len) > MIN_LEN)
        for (int i = 0; i < 4; i++) r[i] = sat_word((r[i] * ONE_Q) / longint'(len));
    end else begin
      theta = arc_cosine(dot * (64'sd1 << (kcs_pkg::CQ - kcs_pkg::FRAC_BITS)));
      s_full = sine(theta);
      s_a = sine(((ONE_Q - t) * theta) >>> kcs_pkg::FRAC_BITS);
      s_b = sine((t * theta) >>> kcs_pkg::FRAC_BITS);
      if (s_full < 1) s_full = 1;
      wa = clamp_w((s_a * (64'sd1 << kcs_pkg::CQ)) / s_full);
      wb = clamp_w((s_b * (64'sd1 << kcs_pkg::CQ)) / s_full);
      for (int i = 0; i < 4; i++)
        r[i] = sat_word((wa * a[i] + wb * b2[i]) >>> kcs_pkg::CQ);
    end
    return r;
  endfunction

  function automatic sample_out_t sample_channel(logic [31:0] st);
    sample_out_t o;
    quad_t r;
    quad_t a;
    quad_t b;
    longint tm;
    longint t;
    longint span;
    longint num;
    int n;
    int lo;
    int hi;
    int mid;
    n = (cfg_count > KEYS) ? KEYS : int'(cfg_count);
    r = '{0, 0, 0, 0};
    o.no_keys = 1'b0;
    tm = longint'(signed'(st));
    if (n == 0) begin
      o.no_keys = 1'b1;
    end else if (n == 1 || tm <= key_tm[0]) begin
      r = key_at(0);
    end else if (tm >= key_tm[n - 1]) begin
      r = key_at(n - 1);
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (key_tm[mid] <= tm) lo = mid;
        else hi = mid;
      end
      if (!cfg_linear) begin
        r = key_at(lo);
      end else begin
        t = 0;
        span = longint'(key_tm[hi]) - longint'(key_tm[lo]);
        num = tm - longint'(key_tm[lo]);
        if (span > 0 && num > 0) begin
          t = (num * ONE_Q) / span;
          if (t > ONE_Q) t = ONE_Q;
        end
        a = key_at(lo);
        b = key_at(hi);
        if (cfg_rotation) begin
          r = rotation_blend(a, b, t);
        end else begin
          for (int k = 0; k < 3; k++)
            r[k] = sat_word(a[k] + ((t * (b[k] - a[k])) >>> kcs_pkg::FRAC_BITS));
        end
      end
    end
    if (!cfg_rotation) r[3] = 0;
    o.x = r[0][31:0];
    o.y = r[1][31:0];
    o.z = r[2][31:0];
    o.w = r[3][31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    sample_out_t e;
    if (hold_len > 0) begin
      m_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
      end else begin
        e = expected_samples.pop_front();
        if (m_tdata[31:0] !== e.x) report_mismatch("out_x", m_tdata[31:0], e.x);
        if (m_tdata[63:32] !== e.y) report_mismatch("out_y", m_tdata[63:32], e.y);
        if (m_tdata[95:64] !== e.z) report_mismatch("out_z", m_tdata[95:64], e.z);
        if (m_tdata[127:96] !== e.w) report_mismatch("out_w", m_tdata[127:96], e.w);
        if (m_tuser !== e.no_keys) report_mismatch("no_keys", 32'(m_tuser), 32'(e.no_keys));
      end
    end
  end

  task automatic send_beat(logic mode, logic [7:0] idx, logic [31:0] kt, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz, logic [31:0] vw,
                           logic [31:0] st);
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {st, vw, vz, vy, vx, kt, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == kcs_pkg::MODE_LOAD) begin
      key_tm[idx] = kt;
      key_val[idx] = '{vx, vy, vz, vw};
      if (int'(idx) == written_n) written_n++;
    end else begin
      expected_samples.push_back(sample_channel(st));
    end
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_key(int idx, logic [31:0] kt, logic [31:0] vx, logic [31:0] vy,
                          logic [31:0] vz, logic [31:0] vw);
    send_beat(kcs_pkg::MODE_LOAD, idx[7:0], kt, vx, vy, vz, vw, $urandom());
  endtask

  task automatic sample_at(logic [31:0] st);
    send_beat(kcs_pkg::MODE_SAMPLE, 8'($urandom()), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), st);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] regno, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regno, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regno)
      kcs_pkg::REG_ROTATION: cfg_rotation = value[0];
      kcs_pkg::REG_LINEAR: cfg_linear = value[0];
      kcs_pkg::REG_COUNT: cfg_count = value[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic rot, logic lin, int cnt);
    drain();
    apb_write(kcs_pkg::REG_ROTATION, 32'(rot));
    apb_write(kcs_pkg::REG_LINEAR, 32'(lin));
    apb_write(kcs_pkg::REG_COUNT, 32'(cnt));
  endtask

  function automatic logic [31:0] rand_component(bit full);
    if (full) return $urandom();
    return 32'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic [31:0] rand_key_time(int idx);
    if ($urandom_range(9) == 0) return $urandom();
    return 32'((idx << 16) + int'($urandom_range(0, 32767)));
  endfunction

  task automatic random_load;
    int idx;
    int src;
    bit full;
    idx = $urandom_range(0, (written_n < KEYS) ? written_n : KEYS - 1);
    full = ($urandom_range(4) == 0);
    if (idx > 0 && $urandom_range(4) == 0) begin
      src = idx - 1;
      load_key(idx, rand_key_time(idx),
               key_val[src][0] + 32'($urandom_range(0, 63)),
               key_val[src][1] - 32'($urandom_range(0, 63)),
               key_val[src][2] + 32'($urandom_range(0, 63)),
               key_val[src][3] + 32'($urandom_range(0, 63)));
    end else begin
      load_key(idx, rand_key_time(idx), rand_component(full), rand_component(full),
               rand_component(full), rand_component(full));
    end
  endtask

  task automatic random_sample;
    int n;
    n = (cfg_count > KEYS) ? KEYS : int'(cfg_count);
    if ($urandom_range(6) == 0) sample_at($urandom());
    else sample_at(32'(int'($urandom_range(0, (n + 1) << 16)) - 32768));
  endtask

  task automatic test_empty_table;
    set_config(1'b0, 1'b0, 0);
    sample_at(32'h8000_0000);
    sample_at(32'h7FFF_FFFF);
    set_config(1'b1, 1'b1, 0);
    sample_at(32'h0);
  endtask

  task automatic test_directed_keys;
    load_key(0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    load_key(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_B505, 32'h0000_B505);
    load_key(2, 32'h0002_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0, 32'hFFFF_4AFB);
    load_key(3, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    load_key(4, 32'h0001_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    set_config(1'b0, 1'b0, 1);
    sample_at(32'h0001_8000);
    set_config(1'b0, 1'b0, 4);
    sample_at(32'h8000_0000);
    sample_at(32'h0001_8000);
    sample_at(32'h7FFF_FFFF);
    set_config(1'b0, 1'b1, 4);
    sample_at(32'h0000_4000);
    sample_at(32'h0002_C000);
    set_config(1'b1, 1'b1, 4);
    sample_at(32'h0000_8000);
    sample_at(32'h0001_4000);
    sample_at(32'h0002_8000);
    set_config(1'b1, 1'b1, 5);
    sample_at(32'h0001_0000);
    sample_at(32'h0002_8000);
    set_config(1'b0, 1'b1, 5);
    sample_at(32'h0002_0000);
  endtask

  task automatic test_full_table;
    for (int i = written_n; i < KEYS; i++)
      load_key(i, 32'((i << 16) + int'($urandom_range(0, 32767))), rand_component(0),
               rand_component(0), rand_component(0), rand_component(0));
    set_config(1'b0, 1'b1, 256);
    repeat (4) random_sample();
    set_config(1'b1, 1'b1, 511);
    repeat (4) random_sample();
    set_config(1'b0, 1'b0, 300);
    repeat (4) random_sample();
  endtask

  task automatic test_backpressure;
    set_config(1'b0, 1'b0, 8);
    hold_len = 400;
    repeat (30) random_sample();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    int cnt;
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(19) == 0) cnt = 0;
      else if ($urandom_range(9) == 0) cnt = $urandom_range(257, 511);
      else cnt = $urandom_range(1, 16);
      set_config($urandom_range(1), $urandom_range(3) != 0, cnt);
      repeat (30) begin
        if ($urandom_range(9) < 3) random_load();
        else random_sample();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    written_n = 0;
    hold_len = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_rotation = 1'b0;
    cfg_linear = 1'b0;
    cfg_count = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_keys();
    test_full_table();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(58, 0);
    test_random_phase(0, 58);
    test_random_phase(29, 29);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/kcs_pkg.sv
sv/kcs_ram.sv
sv/keyframe_channel_sampler_unit.sv
dv/keyframe_channel_sampler_unit_test.sv
